### rtl/core/tli_pkg.sv
// Shared types and constants for the table linear interpolator.
// Used by the front, back and top modules of the block; depends on nothing else.
package tli_pkg;

  localparam int TableDepth    = 1024;
  localparam int AddrWidth     = 10;
  localparam int ValueWidth    = 32;
  localparam int SizeWidth     = 11;
  localparam int IndexWidth    = 12;
  localparam int QueueDepth    = 4;
  localparam int QueuePtrWidth = 2;
  localparam int DivSteps      = 66;
  localparam int DivCntWidth   = 7;

  typedef enum logic [1:0] {
    ST_INTERP     = 2'd0,
    ST_CLAMP      = 2'd1,
    ST_RANGE_ERR  = 2'd2,
    ST_ZERO_WIDTH = 2'd3
  } status_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic {
    CFG_TABLE_SIZE = 1'b0,
    CFG_RANGE_MODE = 1'b1
  } cfg_index_t;

  // One input item as it waits in the front queue.
  typedef struct packed {
    action_t                       action;
    logic [AddrWidth-1:0]          entry_index;
    logic signed [ValueWidth-1:0]  point_x;
    logic signed [ValueWidth-1:0]  point_y;
  } item_t;

  // Head of the front queue as seen by the back part.
  typedef struct packed {
    logic  valid;
    logic  is_query;
    item_t item;
  } head_t;

  // Configuration as used by the back part.
  typedef struct packed {
    logic [SizeWidth-1:0] n;
    logic [AddrWidth-1:0] last_index;
    logic                 clamp_mode;
  } cfg_t;

endpackage

### rtl/core/tli_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package dependency.
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/tli_front.sv
// Front part: accepts input items into a short queue and classifies them.
// Depends on tli_pkg.
module tli_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  tli_pkg::item_t  item,
  output tli_pkg::head_t  head,
  input  logic            head_pop
);

  tli_pkg::item_t                      slot_r [tli_pkg::QueueDepth];
  logic [tli_pkg::QueuePtrWidth-1:0]   wr_ptr_r;
  logic [tli_pkg::QueuePtrWidth-1:0]   rd_ptr_r;
  logic [tli_pkg::QueuePtrWidth:0]     count_r;
  logic                                do_push;
  logic                                do_pop;

  assign full    = (count_r == (tli_pkg::QueuePtrWidth+1)'(tli_pkg::QueueDepth));
  assign do_push = push && !full;
  assign do_pop  = head_pop && head.valid;

  // The head carries its kind so the back part can dispatch at once.
  assign head.valid    = (count_r != '0);
  assign head.item     = slot_r[rd_ptr_r];
  assign head.is_query = (slot_r[rd_ptr_r].action == tli_pkg::ACT_QUERY);

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/core/tli_back.sv
// Back part: table writes, end checks, binary search, multiply and divide.
// Depends on tli_pkg and tli_ram.
module tli_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tli_pkg::cfg_t        cfg,
  input  tli_pkg::head_t       head,
  output logic                 head_pop,
  output logic                 out_valid,
  input  logic                 out_pop,
  output logic signed [31:0]   out_interp_y,
  output logic signed [11:0]   out_lower_index,
  output logic [1:0]           out_status
);

  typedef enum logic [3:0] {
    S_IDLE, S_E0, S_E1, S_E2, S_SA, S_SB, S_B0, S_B1, S_B2,
    S_M0, S_M1, S_DV, S_NG, S_SM, S_OUT
  } state_t;

  state_t                              state_r;
  logic signed [31:0]                  qx_r, x0_r, y0_r, x1_r, y1_r;
  logic [tli_pkg::AddrWidth-1:0]       lo_r, hi_r;
  logic                                desc_r;
  logic                                qneg_r;
  logic [32:0]                         dy_abs_r, dx_abs_r, dd_abs_r;
  logic [65:0]                         prod_r, quo_r;
  logic [32:0]                         rem_r;
  logic [tli_pkg::DivCntWidth-1:0]     cnt_r;
  logic signed [66:0]                  qs_r;
  logic signed [31:0]                  res_y_r;
  logic signed [11:0]                  res_idx_r;
  tli_pkg::status_t                    res_st_r;
  logic                                out_valid_r;

  logic [tli_pkg::AddrWidth-1:0]       rd_addr;
  logic [31:0]                         rd_axis, rd_value;
  logic signed [31:0]                  axis_s, value_s;
  logic                                wr_en;
  logic [tli_pkg::SizeWidth-1:0]       mid;
  logic [tli_pkg::AddrWidth-1:0]       mid_a;
  logic                                desc;
  logic                                below, above;
  logic                                go_lo;
  logic signed [32:0]                  dd, dy, dx;
  logic [16:0]                         mop;
  logic [49:0]                         mprod;
  logic [33:0]                         rem_sh, rem_diff;
  logic                                rem_ge;
  logic signed [67:0]                  sum;
  logic                                sum_fits;

  // Table storage, written in arrival order with the queries.
  assign wr_en = (state_r == S_IDLE) && head.valid && !head.is_query;

  tli_ram #(.WIDTH(32), .DEPTH(tli_pkg::TableDepth)) u_axis (
    .clk(clk), .wr_en(wr_en), .wr_addr(head.item.entry_index),
    .wr_data(head.item.point_x), .rd_addr(rd_addr), .rd_data(rd_axis)
  );

  tli_ram #(.WIDTH(32), .DEPTH(tli_pkg::TableDepth)) u_value (
    .clk(clk), .wr_en(wr_en), .wr_addr(head.item.entry_index),
    .wr_data(head.item.point_y), .rd_addr(rd_addr), .rd_data(rd_value)
  );

  assign axis_s  = rd_axis;
  assign value_s = rd_value;
  assign head_pop = (state_r == S_IDLE) && head.valid;

  // Search midpoint, rounded up.
  assign mid   = ({1'b0, lo_r} + {1'b0, hi_r} + 11'd1) >> 1;
  assign mid_a = mid[tli_pkg::AddrWidth-1:0];

  // Read address for each step of the sequence.
  always_comb begin
    case (state_r)
      S_E1:    rd_addr = cfg.last_index;
      S_SA:    rd_addr = mid_a;
      S_B0:    rd_addr = lo_r;
      S_B1:    rd_addr = lo_r + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  // End checks: the axis descends unless its first x is below its last.
  assign desc  = !(x0_r < axis_s);
  assign below = desc ? (qx_r > x0_r) : (qx_r < x0_r);
  assign above = desc ? (qx_r < axis_s) : (qx_r > axis_s);

  // One search step: the read data holds the midpoint entry just read.
  assign go_lo  = desc_r ? (qx_r < axis_s) : !(qx_r < axis_s);

  // Interval differences on 33 bits.
  assign dd = {axis_s[31], axis_s} - {x1_r[31], x1_r};
  assign dy = {value_s[31], value_s} - {y1_r[31], y1_r};
  assign dx = {qx_r[31], qx_r} - {x1_r[31], x1_r};

  // One 33 by 17 multiplier, used for the low and the high half of dx.
  assign mop   = (state_r == S_M1) ? {1'b0, dx_abs_r[32:17]} : dx_abs_r[16:0];
  assign mprod = {17'b0, dy_abs_r} * {33'b0, mop};

  // One restoring division step.
  assign rem_sh   = {rem_r, prod_r[65]};
  assign rem_ge   = (rem_sh >= {1'b0, dd_abs_r});
  assign rem_diff = rem_sh - {1'b0, dd_abs_r};

  // Final add and saturation check.
  assign sum      = {qs_r[66], qs_r} + {{36{y1_r[31]}}, y1_r};
  assign sum_fits = (sum[67:31] == '0) || (sum[67:31] == '1);

  // Sequencer.
  logic [tli_pkg::AddrWidth-1:0] search_mid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (head.valid && head.is_query) begin
            qx_r    <= head.item.point_x;
            state_r <= S_E0;
          end
        end
        S_E0: state_r <= S_E1;
        S_E1: begin
          x0_r    <= axis_s;
          y0_r    <= value_s;
          state_r <= S_E2;
        end
        S_E2: begin
          desc_r <= desc;
          if (above || below) begin
            res_idx_r <= above ? $signed({1'b0, cfg.n}) : -12'sd1;
            if (cfg.clamp_mode) begin
              res_y_r  <= above ? value_s : y0_r;
              res_st_r <= tli_pkg::ST_CLAMP;
            end else begin
              res_y_r  <= '0;
              res_st_r <= tli_pkg::ST_RANGE_ERR;
            end
            state_r <= S_OUT;
          end else begin
            lo_r    <= '0;
            hi_r    <= cfg.last_index;
            state_r <= (cfg.last_index == 10'd1) ? S_B0 : S_SA;
          end
        end
        S_SA: begin
          search_mid_r <= mid_a;
          state_r      <= S_SB;
        end
        S_SB: begin
          if (go_lo) begin
            lo_r <= search_mid_r;
            state_r <= (hi_r == search_mid_r + 1'b1) ? S_B0 : S_SA;
          end else begin
            hi_r <= search_mid_r;
            state_r <= (search_mid_r == lo_r + 1'b1) ? S_B0 : S_SA;
          end
        end
        S_B0: state_r <= S_B1;
        S_B1: begin
          x1_r    <= axis_s;
          y1_r    <= value_s;
          state_r <= S_B2;
        end
        S_B2: begin
          res_idx_r <= $signed({2'b0, lo_r});
          if (dd == '0) begin
            res_y_r  <= '0;
            res_st_r <= tli_pkg::ST_ZERO_WIDTH;
            state_r  <= S_OUT;
          end else begin
            qneg_r   <= dy[32] ^ dx[32] ^ dd[32];
            dy_abs_r <= dy[32] ? 33'(-dy) : 33'(dy);
            dx_abs_r <= dx[32] ? 33'(-dx) : 33'(dx);
            dd_abs_r <= dd[32] ? 33'(-dd) : 33'(dd);
            state_r  <= S_M0;
          end
        end
        S_M0: begin
          prod_r  <= {16'b0, mprod};
          state_r <= S_M1;
        end
        S_M1: begin
          prod_r  <= prod_r + {mprod[48:0], 17'b0};
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DV;
        end
        S_DV: begin
          rem_r  <= rem_ge ? rem_diff[32:0] : rem_sh[32:0];
          prod_r <= {prod_r[64:0], 1'b0};
          quo_r  <= {quo_r[64:0], rem_ge};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == tli_pkg::DivCntWidth'(tli_pkg::DivSteps - 1)) begin
            state_r <= S_NG;
          end
        end
        S_NG: begin
          qs_r    <= qneg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
          state_r <= S_SM;
        end
        S_SM: begin
          res_st_r <= tli_pkg::ST_INTERP;
          if (sum_fits) begin
            res_y_r <= sum[31:0];
          end else begin
            res_y_r <= sum[67] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_pop) begin
            out_interp_y    <= res_y_r;
            out_lower_index <= res_idx_r;
            out_status      <= res_st_r;
            out_valid_r     <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/table_linear_interpolator_top.sv
// Top level of the table linear interpolator: configuration registers,
// front queue and back sequencer. Depends on tli_pkg, tli_front, tli_back.
//
// Usage: items enter through a queue-style port (in_push, in_full). A write
// item (action 0) stores point_x and point_y at entry_index and gives no
// result. A query item (action 1) gives one result on the out_ side, which
// reads like a queue: the result stands on the ports while out_empty is low
// and is taken by out_pop. Configuration writes use cfg_valid/cfg_ready
// (always ready), index 0 table_size, index 1 out_of_range_mode.
// A write is done when it leaves the queue head into the table memory. An
// out-of-range query ends after the end checks; an in-range query runs the
// binary search, each step of which reads the registered table memory, then
// the multiply and the one-bit-per-cycle 66-step divider.
// Items are carried out one at a time; the four-entry front queue keeps
// accepting while a query is at work or a result waits.
// Reset clears the queues and sets table_size to 2 and clamping on; table
// contents stay undefined until written. A stalled receiver holds the result
// and, once the next result is ready, halts the back part; the front queue
// then fills and raises in_full.
module table_linear_interpolator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_action,
  input  logic [9:0]          in_entry_index,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [31:0]  out_interp_y,
  output logic signed [11:0]  out_lower_index,
  output logic [1:0]          out_status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data
);

  logic [tli_pkg::SizeWidth-1:0] table_size_r;
  logic                          range_mode_r;
  tli_pkg::cfg_t                 cfg;
  tli_pkg::item_t                item;
  tli_pkg::head_t                head;
  logic                          head_pop;
  logic                          out_valid;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= 11'd2;
      range_mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (tli_pkg::cfg_index_t'(cfg_index))
        tli_pkg::CFG_TABLE_SIZE: table_size_r <= cfg_data;
        tli_pkg::CFG_RANGE_MODE: range_mode_r <= cfg_data[0];
        default:                 table_size_r <= table_size_r;
      endcase
    end
  end

  // Table size limited to the usable range.
  always_comb begin
    if (table_size_r < 11'd2) begin
      cfg.n = 11'd2;
    end else if (table_size_r > 11'(tli_pkg::TableDepth)) begin
      cfg.n = 11'(tli_pkg::TableDepth);
    end else begin
      cfg.n = table_size_r;
    end
    cfg.last_index = 10'(cfg.n - 11'd1);
    cfg.clamp_mode = range_mode_r;
  end

  assign item.action      = tli_pkg::action_t'(in_action);
  assign item.entry_index = in_entry_index;
  assign item.point_x     = in_point_x;
  assign item.point_y     = in_point_y;

  tli_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full),
    .item(item), .head(head), .head_pop(head_pop)
  );

  tli_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .head(head), .head_pop(head_pop),
    .out_valid(out_valid), .out_pop(out_pop), .out_interp_y(out_interp_y),
    .out_lower_index(out_lower_index), .out_status(out_status)
  );

  assign out_empty = !out_valid;

`ifndef SYNTHESIS
  // An error or a zero-width interval always gives a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_status == tli_pkg::ST_RANGE_ERR ||
                   out_status == tli_pkg::ST_ZERO_WIDTH) |-> out_interp_y == '0)
    else $error("nonzero value with error status");

  // An interpolated result brackets inside the table in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status == tli_pkg::ST_INTERP |->
      !out_lower_index[11] && out_lower_index[10:0] < cfg.last_index + 11'd1 - 11'd1)
    else $error("bracket index outside the table");

  // An out-of-range error reports one of the two table ends.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status == tli_pkg::ST_RANGE_ERR |->
      out_lower_index == -12'sd1 || out_lower_index == $signed({1'b0, cfg.n}))
    else $error("range error without end index");
`endif

endmodule

### sim/tb_table_linear_interpolator_top.sv
// Self-checking testbench for the table linear interpolator top level.
// Depends on tli_pkg and table_linear_interpolator_top with its submodules.
module tb_table_linear_interpolator_top;
  import tli_pkg::*;

  localparam longint CycleLimit = 3000000;
  localparam int     SettleCycles = 200;
  localparam int     ItemTarget = 1150;

  typedef struct {
    action_t           action;
    logic [9:0]        entry_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } table_item_t;

  typedef struct {
    logic signed [31:0] interp_y;
    logic [11:0]        lower_index;
    status_t            status;
  } lookup_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_action = 1'b0;
  logic [9:0]         in_entry_index = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_interp_y;
  logic signed [11:0] out_lower_index;
  logic [1:0]         out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [10:0]        cfg_data = '0;

  table_linear_interpolator_top DUT (.*);

  always #5 clk = ~clk;

  // Predictor state: table contents and configuration as the block sees them.
  logic signed [31:0] axis_mem [TableDepth];
  logic signed [31:0] value_mem [TableDepth];
  int unsigned        mdl_size = 2;
  logic               mdl_clamp = 1'b1;

  table_item_t pending_items[$];
  lookup_t     lookups_due[$];
  int          idle_level = 1;
  int          items_queued = 0;
  int          mismatches = 0;
  longint      cycle_count = 0;
  bit          took = 0;
  int          push_gap = 0;
  int          pop_gap = 0;
  int          hold_left = 0;
  int          queries_seen = 0;
  bit          hold_done = 0;

  // Plan of the table as the stimulus builds it.
  longint plan_x [TableDepth];
  longint plan_y [TableDepth];

  function automatic int unsigned used_size(int unsigned raw);
    if (raw < 2) return 2;
    if (raw > TableDepth) return TableDepth;
    return raw;
  endfunction

  // Left bracket search plus truncated, saturated linear interpolation.
  function automatic lookup_t interpolate(logic signed [31:0] qx);
    lookup_t            r;
    int unsigned        n, lo, hi, mid;
    int                 idx;
    logic               desc;
    logic signed [33:0] dy, dx, dd;
    logic [33:0]        dya, dxa, dda;
    logic [67:0]        quot;
    logic signed [71:0] acc;
    logic               qneg;
    n = used_size(mdl_size);
    desc = !(axis_mem[0] < axis_mem[n-1]);
    idx = 0;
    if (!desc) begin
      if (qx < axis_mem[0]) idx = -1;
      if (qx > axis_mem[n-1]) idx = n;
    end else begin
      if (qx > axis_mem[0]) idx = -1;
      if (qx < axis_mem[n-1]) idx = n;
    end
    r.interp_y = '0;
    r.lower_index = 12'(idx);
    if (idx == -1 || idx == int'(n)) begin
      if (mdl_clamp) begin
        r.interp_y = (idx == -1) ? value_mem[0] : value_mem[n-1];
        r.status = ST_CLAMP;
      end else begin
        r.status = ST_RANGE_ERR;
      end
      return r;
    end
    lo = 0;
    hi = n - 1;
    while (hi != lo + 1) begin
      mid = (lo + hi + 1) >> 1;
      if (!desc) begin
        if (qx < axis_mem[mid]) hi = mid; else lo = mid;
      end else begin
        if (qx < axis_mem[mid]) lo = mid; else hi = mid;
      end
    end
    r.lower_index = 12'(lo);
    dd = 34'(axis_mem[lo+1]) - 34'(axis_mem[lo]);
    if (dd == 0) begin
      r.status = ST_ZERO_WIDTH;
      return r;
    end
    dy = 34'(value_mem[lo+1]) - 34'(value_mem[lo]);
    dx = 34'(qx) - 34'(axis_mem[lo]);
    dya = dy < 0 ? -dy : dy;
    dxa = dx < 0 ? -dx : dx;
    dda = dd < 0 ? -dd : dd;
    qneg = (dy[33] != dx[33]) != dd[33];
    quot = (68'(dya) * 68'(dxa)) / 68'(dda);
    acc = $signed(72'(quot));
    if (qneg) acc = -acc;
    acc = acc + 72'(value_mem[lo]);
    if (acc > 72'sd2147483647) r.interp_y = 32'h7FFF_FFFF;
    else if (acc < -72'sd2147483648) r.interp_y = 32'h8000_0000;
    else r.interp_y = acc[31:0];
    r.status = ST_INTERP;
    return r;
  endfunction

  function automatic int draw_gap();
    int roll;
    if (idle_level == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sender: offers the next pending item once the previous transfer is done.
  always @(negedge clk) begin
    if (rst_n && (took || !in_push)) begin
      if (push_gap > 0) begin
        push_gap <= push_gap - 1;
        in_push <= 1'b0;
      end else if (pending_items.size() > 0) begin
        table_item_t it;
        it = pending_items.pop_front();
        in_action <= it.action;
        in_entry_index <= it.entry_index;
        in_point_x <= it.point_x;
        in_point_y <= it.point_y;
        in_push <= 1'b1;
        push_gap <= draw_gap();
      end else begin
        in_push <= 1'b0;
      end
    end
    took = 0;
  end

  // Input transfers update the predictor.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      took = 1;
      if (in_action == ACT_WRITE) begin
        axis_mem[in_entry_index] = in_point_x;
        value_mem[in_entry_index] = in_point_y;
      end else begin
        lookups_due.push_back(interpolate(in_point_x));
      end
    end
  end

  // One long receiver hold-off once traffic is flowing, so that in_full rises.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full && in_action == ACT_QUERY)
      queries_seen <= queries_seen + 1;
    if (!hold_done && queries_seen == 250) begin
      hold_left <= 800;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls, short mostly.
  always @(negedge clk) begin
    if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= (hold_left == 0);
      pop_gap <= draw_gap();
    end
  end

  // Result transfers are checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (lookups_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: y=%0d idx=%0d status=%0d",
                   out_interp_y, out_lower_index, out_status);
      end else begin
        lookup_t e;
        e = lookups_due.pop_front();
        if (out_interp_y !== e.interp_y || out_lower_index !== e.lower_index ||
            out_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected y=%0d idx=%0d status=%0d, got y=%0d idx=%0d status=%0d",
                     e.interp_y, $signed(e.lower_index), e.status,
                     out_interp_y, out_lower_index, out_status);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_write(int idx, longint x, longint y);
    table_item_t it;
    it.action = ACT_WRITE;
    it.entry_index = 10'(idx);
    it.point_x = 32'(x);
    it.point_y = 32'(y);
    pending_items.push_back(it);
    items_queued++;
    if (idx < TableDepth) begin
      plan_x[idx] = 64'($signed(32'(x)));
      plan_y[idx] = 64'($signed(32'(y)));
    end
  endtask

  task automatic queue_query(longint x);
    table_item_t it;
    it.action = ACT_QUERY;
    it.entry_index = 10'($urandom);
    it.point_x = 32'(x);
    it.point_y = 32'($urandom);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Waits until every item is taken and every result has arrived.
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_push || lookups_due.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, int unsigned data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = 11'(data);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TABLE_SIZE) mdl_size = data & 11'h7FF;
    else mdl_clamp = data[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic longint rand64();
    return longint'({$urandom, $urandom});
  endfunction

  // Builds and loads a table of the given shape, then queries it.
  task automatic run_phase(int unsigned size_raw, int mode, int shape, int nq);
    int unsigned n;
    longint      step_cap, cur, lo_x, hi_x, a, b, span;
    int          i, k, roll;
    wait_idle();
    cfg_write(CFG_TABLE_SIZE, size_raw);
    cfg_write(CFG_RANGE_MODE, mode);
    n = used_size(size_raw);
    step_cap = 64'hFFFF_FFFF / (n - 1);
    step_cap = step_cap >> $urandom_range(0, 24);
    cur = -64'sd2147483648 + (rand64() & 64'hFFFF) ;
    for (i = 0; i < n; i++) begin
      if (shape == 2) plan_x[i] = 64'($signed($urandom));
      else if (shape == 4) plan_x[i] = (i == 0) ? 64'($signed($urandom)) : plan_x[0];
      else begin
        if (i > 0 && !(shape == 3 && $urandom_range(0, 3) == 0))
          cur = cur + ((rand64() & 64'h7FFF_FFFF_FFFF_FFFF) % (step_cap + 1));
        if (cur > 64'sd2147483647) cur = 64'sd2147483647;
        plan_x[i] = cur;
      end
    end
    // Descending shape mirrors the ascending axis.
    if (shape == 1)
      for (i = 0; i < n / 2; i++) begin
        a = plan_x[i]; plan_x[i] = plan_x[n-1-i]; plan_x[n-1-i] = a;
      end
    for (i = 0; i < n; i++)
      queue_write(i, plan_x[i], 64'($signed($urandom)));
    for (k = 0; k < nq; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        i = $urandom_range(0, TableDepth - 1);
        queue_write(i, (i < n && shape != 2) ? plan_x[i] : 64'($signed($urandom)),
                    64'($signed($urandom)));
      end else if (roll < 12) begin
        queue_query($urandom_range(0, 1) ? -64'sd2147483648 : 64'sd2147483647);
      end else if (roll < 22) begin
        queue_query(64'($signed($urandom)));
      end else if (roll < 30) begin
        queue_query(plan_x[$urandom_range(0, n - 1)]);
      end else begin
        i = $urandom_range(0, n - 2);
        a = plan_x[i];
        b = plan_x[i+1];
        lo_x = a < b ? a : b;
        hi_x = a < b ? b : a;
        span = hi_x - lo_x + 1;
        queue_query(lo_x + (rand64() & 64'h7FFF_FFFF_FFFF_FFFF) % span);
      end
    end
  endtask

  initial begin
    int p, n_roll;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: full-scale ends with clamping, size written as zero.
    idle_level = 0;
    cfg_write(CFG_TABLE_SIZE, 0);
    queue_write(0, -64'sd2147483648, 64'sd2147483647);
    queue_write(1, 64'sd2147483647, -64'sd2147483648);
    queue_write(1023, 64'sd2147483647, -64'sd2147483648);
    queue_write(1, 64'sd2147483647, -64'sd2147483648);
    queue_query(-64'sd2147483648);
    queue_query(64'sd2147483647);
    queue_query(0);
    queue_query(-1);
    // Error reporting just outside a small ascending interval, and results at its ends and middle.
    wait_idle();
    cfg_write(CFG_RANGE_MODE, 0);
    queue_write(0, -100, 7);
    queue_write(1, 100, -300);
    queue_query(-101);
    queue_query(101);
    queue_query(-100);
    queue_query(100);
    queue_query(0);
    // Clamping on a descending axis.
    wait_idle();
    cfg_write(CFG_RANGE_MODE, 1);
    queue_write(0, 100, 55);
    queue_write(1, -100, -55);
    queue_query(150);
    queue_query(-150);
    queue_query(3);
    // Equal end points give a zero-width interval.
    queue_write(1, 100, 9);
    queue_query(100);

    // Random phases over sizes, shapes and both range modes.
    idle_level = 1;
    p = 0;
    while (items_queued < ItemTarget) begin
      idle_level = (p % 5 == 4) ? 0 : 1;
      n_roll = $urandom_range(0, 9);
      if (p == 3) run_phase(2047, $urandom_range(0, 1), 0, 60);
      else if (p == 6) run_phase(1, 0, 2, 40);
      else if (n_roll < 3) run_phase(2, p % 2, $urandom_range(0, 4), 30);
      else run_phase($urandom_range(3, 40), p % 2, p % 5, $urandom_range(40, 80));
      p++;
    end

    while (pending_items.size() > 0 || in_push || lookups_due.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && lookups_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
rtl/core/tli_pkg.sv
rtl/core/tli_ram.sv
rtl/core/tli_front.sv
rtl/core/tli_back.sv
rtl/core/table_linear_interpolator_top.sv
sim/tb_table_linear_interpolator_top.sv
